### rtl/core/dnh_pkg.sv
// Shared types and constants of the directory name hash block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package dnh_pkg;

    // Field widths
    localparam int HASH_W     = 11;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    // Reset value and queue depth
    localparam logic [HASH_W-1:0] TABLE_SIZE_RST = 11'd72;
    localparam int                QUEUE_DEPTH    = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTL_MODE  = 8'd1;

    // Divider state
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HOLD
    } t_div_state;

    // Finished name hash handed from front to queue
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_push;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/core/dnh_front.sv
// Front part: accepts name bytes, folds case and keeps the running hash.
// Depends on dnh_pkg; pushes each finished name hash toward dnh_queue.
`timescale 1ns / 1ps

module dnh_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [dnh_pkg::BYTE_W-1:0]     i_name_byte,
    input  logic [dnh_pkg::BYTE_W-1:0]     i_name_length,
    input  logic                           i_first_byte,
    input  logic                           i_last_byte,
    input  logic                           i_intl_mode,
    input  dnh_pkg::t_q_stat               i_q_stat,
    output dnh_pkg::t_push                 o_push
);
    import dnh_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] h_base;
    logic [HASH_W-1:0] h_mul;
    logic [BYTE_W-1:0] folded;
    logic              accept;

    // Stall every byte while the hash queue is full
    assign o_tready = ~i_q_stat.full;
    assign accept   = i_tvalid & o_tready;

    // Fold to upper case: ASCII always, Latin-1 lower case in intl mode
    always_comb begin
        folded = i_name_byte;
        if (i_name_byte >= 8'h61 && i_name_byte <= 8'h7A) begin
            folded = i_name_byte - 8'h20;
        end else if (i_intl_mode && i_name_byte >= 8'hE0 && i_name_byte <= 8'hFE
                     && i_name_byte != 8'hF7) begin
            folded = i_name_byte - 8'h20;
        end
    end

    // Mix: hash * 13 + folded, kept to 11 bits
    assign h_base = i_first_byte ? {{(HASH_W-BYTE_W){1'b0}}, i_name_length} : r_hash;
    assign h_mul  = (h_base << 3) + (h_base << 2) + h_base;
    assign n_hash = h_mul + {{(HASH_W-BYTE_W){1'b0}}, folded};

    // Advance the hash on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (accept) begin
            r_hash <= n_hash;
        end
    end

    // Push on the last byte of a name
    assign o_push.valid = accept & i_last_byte;
    assign o_push.hash  = n_hash;

endmodule

### rtl/core/dnh_queue.sv
// Short queue of finished name hashes between front and back.
// Depends on dnh_pkg for the push and status types.
`timescale 1ns / 1ps

module dnh_queue #(
    parameter int Depth = dnh_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dnh_pkg::t_push              i_push,
    input  logic                        i_pop,
    output logic [dnh_pkg::HASH_W-1:0]  o_hash,
    output dnh_pkg::t_q_stat            o_q_stat
);
    import dnh_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    logic [HASH_W-1:0] r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_q_stat.full  = (r_count == CntFull);
    assign o_q_stat.empty = (r_count == '0);
    assign do_push = i_push.valid & ~o_q_stat.full;
    assign do_pop  = i_pop & ~o_q_stat.empty;
    assign o_hash  = r_mem[r_rd_ptr];

    // Store pushed hash
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.hash;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/dnh_back.sv
// Back part: reduces each queued hash modulo the table size, one bit a cycle.
// Depends on dnh_pkg; holds the result in an output register for the stream.
`timescale 1ns / 1ps

module dnh_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dnh_pkg::t_q_stat            i_q_stat,
    input  logic [dnh_pkg::HASH_W-1:0]  i_hash,
    output logic                        o_pop,
    input  logic [dnh_pkg::HASH_W-1:0]  i_table_size,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [dnh_pkg::HASH_W-1:0]  o_bucket
);
    import dnh_pkg::*;

    localparam int StepW = $clog2(HASH_W);
    localparam logic [StepW-1:0] StepLast = StepW'(HASH_W - 1);

    t_div_state        r_state;
    t_div_state        n_state;
    logic [StepW-1:0]  r_step;
    logic [HASH_W-1:0] r_rem;
    logic [HASH_W-1:0] r_dvd;
    logic [HASH_W-1:0] r_bucket;
    logic              r_out_valid;
    logic [HASH_W:0]   shifted;
    logic [HASH_W:0]   diff;
    logic              fits;
    logic              load_out;
    logic              calc_done;

    // Restoring step: shift in one dividend bit, subtract if it fits
    assign shifted = {r_rem, r_dvd[HASH_W-1]};
    assign diff    = shifted - {1'b0, i_table_size};
    assign fits    = (shifted >= {1'b0, i_table_size});

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_q_stat.empty) n_state = S_CALC;
            S_CALC:  if (r_step == StepLast) n_state = S_HOLD;
            S_HOLD:  if (!r_out_valid || i_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop     = 1'b0;
        calc_done = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE:  o_pop     = ~i_q_stat.empty;
            S_CALC:  calc_done = (r_step == StepLast);
            S_HOLD:  load_out  = ~r_out_valid | i_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load the dividend on pop, then iterate
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dvd  <= i_hash;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == S_CALC && !calc_done) begin
            r_dvd  <= r_dvd << 1;
            r_rem  <= fits ? diff[HASH_W-1:0] : shifted[HASH_W-1:0];
            r_step <= r_step + 1'b1;
        end else if (calc_done) begin
            r_rem  <= fits ? diff[HASH_W-1:0] : shifted[HASH_W-1:0];
        end
    end

    // Output register; a zero table size gives bucket zero
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_bucket <= (i_table_size == '0) ? '0 : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_bucket = r_bucket;

endmodule

### rtl/core/directory_name_hash_core.sv
// Directory name hash: one name byte per cycle in, one bucket per name out.
// Throughput: one byte per cycle while the hash queue has room; the back
// divider takes one name at a time (11 restoring steps, load and hand-off).
// A finished hash passes through the queue, the divider and the output register.
// Reset: synchronous, active low; clears hash, queue, divider and output valid,
// and sets table_size to 72 and intl_mode to 0.
`timescale 1ns / 1ps

module directory_name_hash_core #(
    parameter int QueueDepth = dnh_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input name stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dnh_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] name_byte, [15:8] name_length
    input  logic                            s_axis_tlast,  // last_byte
    input  logic                            s_axis_tuser,  // first_byte
    // Output bucket stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dnh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [10:0] bucket_index, [15:11] zero
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dnh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dnh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dnh_pkg::*;

    logic [HASH_W-1:0] r_table_size;
    logic              r_intl_mode;
    t_push             push;
    t_q_stat           q_stat;
    logic              pop;
    logic [HASH_W-1:0] q_hash;
    logic [HASH_W-1:0] bucket;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
            r_intl_mode  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data[HASH_W-1:0];
                CFG_INTL_MODE:  r_intl_mode  <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    dnh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tvalid      (s_axis_tvalid),
        .o_tready      (s_axis_tready),
        .i_name_byte   (s_axis_tdata[7:0]),
        .i_name_length (s_axis_tdata[15:8]),
        .i_first_byte  (s_axis_tuser),
        .i_last_byte   (s_axis_tlast),
        .i_intl_mode   (r_intl_mode),
        .i_q_stat      (q_stat),
        .o_push        (push)
    );

    dnh_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_hash   (q_hash),
        .o_q_stat (q_stat)
    );

    dnh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_hash       (q_hash),
        .o_pop        (pop),
        .i_table_size (r_table_size),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_bucket     (bucket)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-HASH_W){1'b0}}, bucket};

endmodule

### rtl/core/dnh_checker.sv
// Port-level checks of the directory name hash core, bound to the top level.
// Depends on dnh_pkg; tracks table_size from the configuration channel.
`timescale 1ns / 1ps

module dnh_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [dnh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [dnh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [dnh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dnh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dnh_pkg::*;

    logic [HASH_W-1:0] r_tbl;

    // Mirror table_size as written on the configuration channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl <= TABLE_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_TABLE_SIZE) begin
            r_tbl <= i_cfg_data[HASH_W-1:0];
        end
    end

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled bucket changed");

    // Bucket lies below the table size
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_tbl != '0 |-> m_axis_tdata[HASH_W-1:0] < r_tbl)
        else $error("bucket not below table size");

    // Zero table size gives bucket zero, pad bits stay zero
    a_bucket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_tbl == '0 |-> m_axis_tdata == '0)
        else $error("nonzero bucket with zero table size");

endmodule

bind directory_name_hash_core dnh_checker u_dnh_checker (.*);

### test/tb_top.sv
// Testbench of directory_name_hash_core: streams file names one byte per request,
// predicts each name's bucket in a scoreboard class, checks every returned bucket.
// Depends on rtl/core/dnh_pkg.sv and rtl/core/directory_name_hash_core.sv.
`timescale 1ns / 1ps

// Predicts the bucket of every finished name and checks returned buckets in order.
class dnh_bucket_board;
    logic [dnh_pkg::HASH_W-1:0]     table_size;
    logic                           intl_mode;
    logic [dnh_pkg::HASH_W-1:0]     name_hash;
    logic [dnh_pkg::OUT_DATA_W-1:0] bucket_q[$];
    int                             errors;
    int                             shown;

    function new();
        table_size = dnh_pkg::TABLE_SIZE_RST;
        intl_mode  = 1'b0;
        name_hash  = '0;
        errors     = 0;
        shown      = 0;
    endfunction

    // Register write: keep only the low bits of each register
    function void write_reg(logic [dnh_pkg::CFG_IDX_W-1:0] idx,
                            logic [dnh_pkg::CFG_DATA_W-1:0] data);
        if (idx == dnh_pkg::CFG_TABLE_SIZE) begin
            table_size = data[dnh_pkg::HASH_W-1:0];
        end else if (idx == dnh_pkg::CFG_INTL_MODE) begin
            intl_mode = data[0];
        end
    endfunction

    // Fold ASCII lower case always, Latin-1 lower case only in international mode
    function logic [7:0] upper_case(logic [7:0] nb);
        if (nb >= 8'h61 && nb <= 8'h7A) begin
            return nb - 8'h20;
        end
        if (intl_mode && nb >= 8'hE0 && nb <= 8'hFE && nb != 8'hF7) begin
            return nb - 8'h20;
        end
        return nb;
    endfunction

    // Mix one accepted name byte; queue the bucket on the last byte
    function void note_byte(logic [7:0] nb, logic is_first, logic is_last,
                            logic [7:0] len);
        int unsigned h;
        logic [dnh_pkg::HASH_W-1:0] slot;
        h = is_first ? len : name_hash;
        h = (h * 13 + upper_case(nb)) & 32'h7FF;
        name_hash = h[dnh_pkg::HASH_W-1:0];
        if (is_last) begin
            slot = (table_size == 0) ? '0 : name_hash % table_size;
            bucket_q.push_back({{(dnh_pkg::OUT_DATA_W-dnh_pkg::HASH_W){1'b0}}, slot});
        end
    endfunction

    // Compare a returned bucket with the oldest prediction
    function void check_bucket(logic [dnh_pkg::OUT_DATA_W-1:0] got);
        logic [dnh_pkg::OUT_DATA_W-1:0] want;
        if (bucket_q.size() == 0) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("ERROR: bucket %0d returned with no name pending", got);
            end
        end else begin
            want = bucket_q.pop_front();
            if (got !== want) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: bucket_index expected %0d, got %0d", want, got);
                end
            end
        end
    endfunction

    function int pending();
        return bucket_q.size();
    endfunction
endclass

module tb_top;
    import dnh_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 210;
    // Index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] name_byte, [15:8] name_length
    logic                  s_axis_tlast;   // last_byte
    logic                  s_axis_tuser;   // first_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [10:0] bucket_index, [15:11] zero
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dnh_bucket_board board;
    bit              tx_gaps;
    bit              rx_stalls;
    int              idle_cycles;
    int              sent;
    logic [7:0]      edge_bytes[12];

    directory_name_hash_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock: 20 ns period
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Observe requests and buckets at the rising edge; watchdog on silence
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast,
                                s_axis_tdata[15:8]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_bucket(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Bucket receiver: random stall bursts while enabled
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Present one name byte, hold until accepted; returns at a falling edge
    task automatic send_byte(input logic [7:0] nb, input logic is_first,
                             input logic is_last, input logic [7:0] len);
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, nb};
        s_axis_tuser  <= is_first;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    // Drop the request valid and wait for every pending bucket
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write; only called with the block idle; returns at a falling edge after the drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Name byte biased toward letters and the fold boundaries
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'hE0 + 8'($urandom_range(0, 31));
            2: return 8'($urandom_range(0, 255));
            default: return edge_bytes[$urandom_range(0, 11)];
        endcase
    endfunction

    // Well-formed name; the length field sometimes disagrees with the byte count
    task automatic send_name(input int nbytes);
        logic [7:0] len;
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(nbytes);
        for (int i = 0; i < nbytes; i++) begin
            send_byte(pick_byte(), i == 0, i == nbytes - 1,
                      (i == 0) ? len : 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [10:0] ts;
        board         = new();
        edge_bytes    = '{8'h00, 8'h40, 8'h5A, 8'h60, 8'h61, 8'h7A,
                          8'h7B, 8'hDF, 8'hE0, 8'hF7, 8'hFE, 8'hFF};
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        idle_cycles   = 0;
        sent          = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Byte without a first mark right after reset mixes into a zero hash
        send_byte(8'h41, 1'b0, 1'b1, 8'hA5);
        // Single-byte name with length zero
        send_byte(8'h00, 1'b1, 1'b1, 8'h00);
        // Longest length seed, ASCII fold boundaries
        send_byte(8'hFF, 1'b1, 1'b0, 8'hFF);
        send_byte(8'h60, 1'b0, 1'b0, 8'h00);
        send_byte(8'h61, 1'b0, 1'b0, 8'h12);
        send_byte(8'h7A, 1'b0, 1'b0, 8'h34);
        send_byte(8'h7B, 1'b0, 1'b1, 8'h56);
        // Latin-1 bytes with international mode off; length shorter than the name
        send_byte(8'hE0, 1'b1, 1'b0, 8'h02);
        send_byte(8'hF7, 1'b0, 1'b0, 8'h00);
        send_byte(8'hFE, 1'b0, 1'b1, 8'h00);
        // Continue the last hash without a first mark
        send_byte(8'hDF, 1'b0, 1'b1, 8'hFF);
        drain();

        // Latin-1 folding on, smallest table; upper bits of the value dropped
        write_reg(CFG_INTL_MODE, 11'h401);
        write_reg(CFG_TABLE_SIZE, 11'd1);
        write_reg(CFG_IDX_SPARE, 11'h7FF);
        send_byte(8'hE0, 1'b1, 1'b0, 8'h04);
        send_byte(8'hF7, 1'b0, 1'b0, 8'h00);
        send_byte(8'hFE, 1'b0, 1'b0, 8'h00);
        send_byte(8'hFF, 1'b0, 1'b1, 8'h00);
        drain();

        // Zero table size gives bucket zero
        write_reg(CFG_TABLE_SIZE, 11'd0);
        send_byte(8'h7A, 1'b1, 1'b0, 8'h02);
        send_byte(8'hE5, 1'b0, 1'b1, 8'h00);
        drain();

        // Largest table
        write_reg(CFG_TABLE_SIZE, 11'd2047);
        write_reg(CFG_INTL_MODE, 11'h7FE);
        send_byte(8'hFF, 1'b1, 1'b0, 8'hFF);
        send_byte(8'hFF, 1'b0, 1'b1, 8'hFF);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: ts = 11'd72;
                1: ts = 11'd1;
                2: ts = 11'd2047;
                3: ts = 11'd0;
                4: ts = 11'd13;
                default: ts = 11'($urandom_range(1, 2047));
            endcase
            write_reg(CFG_TABLE_SIZE, ts);
            write_reg(CFG_INTL_MODE, (p % 2 == 0) ? 11'h001 : 11'($urandom_range(0, 1)));
            // No idling at all in the closing phase
            tx_gaps   = (p < PHASES - 1);
            rx_stalls = (p < PHASES - 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Stray byte with random marks
                    send_byte(pick_byte(), 1'($urandom), 1'($urandom),
                              8'($urandom_range(0, 255)));
                end else if ($urandom_range(0, 39) == 0) begin
                    send_name($urandom_range(200, 255));
                end else begin
                    send_name($urandom_range(1, 12));
                end
                // Hold off the sender until every bucket is back, midway through phase 2
                if (p == 2 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 12) begin
                    s_axis_tvalid <= 1'b0;
                    while (board.pending() != 0) @(negedge i_clk);
                    @(negedge i_clk);
                end
            end
            drain();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### directory_name_hash_core.f
rtl/core/dnh_pkg.sv
rtl/core/dnh_front.sv
rtl/core/dnh_queue.sv
rtl/core/dnh_back.sv
rtl/core/directory_name_hash_core.sv
rtl/core/dnh_checker.sv
test/tb_top.sv
